// ===== design/solar_to_lunar_date_converter_defines.svh =====
// ----------------------------------------------------------------------------
// solar_to_lunar_date_converter_defines.svh
// assertion macros shared by the date converter rtl
// ----------------------------------------------------------------------------
`ifndef SOLAR_TO_LUNAR_DATE_CONVERTER_DEFINES_SVH
`define SOLAR_TO_LUNAR_DATE_CONVERTER_DEFINES_SVH

// same-cycle implication
`define S2L_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define S2L_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/s2l_pkg.sv =====
// ----------------------------------------------------------------------------
// s2l_pkg
// types, tables and helpers of the solar to lunar date converter
// ----------------------------------------------------------------------------
package s2l_pkg;

  localparam logic [11:0] MIN_YEAR       = 12'd1901;
  localparam logic [11:0] MAX_YEAR       = 12'd2050;
  localparam logic [11:0] ROM_FIRST_YEAR = 12'd1900;
  localparam logic [11:0] BLK1_LAST_YEAR = 12'd1950;
  localparam logic [11:0] BLK2_LAST_YEAR = 12'd2000;
  localparam logic [7:0]  LAST_YEAR_IDX  = 8'd150;
  localparam logic [7:0]  YEARS_PER_BLK  = 8'd50;
  localparam logic [9:0]  LEAP_OFFSET    = 10'd475;
  localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
  localparam logic [8:0]  BASE_DAY       = 9'd31;
  localparam logic [8:0]  TERM_YEAR_MIN  = 9'd348;
  localparam logic [10:0] MIN_PER_DAY    = 11'd1440;
  localparam logic [6:0]  TERM_BIAS      = 7'd125;
  localparam logic [10:0] DIV45_RECIP    = 11'd1456;
  localparam logic [5:0]  DIV45          = 6'd45;
  localparam logic [8:0]  SHORT_YEAR     = 9'd348;
  localparam logic [3:0]  LAST_MONTH     = 4'd12;
  localparam logic [3:0]  TERM_MONTHS    = 4'd13;
  localparam logic [5:0]  NO_TERM        = 6'h3f;

  typedef struct packed {
    logic              err;
    logic [1:0]        blk;
    logic [14:0]       rem;
    logic signed [5:0] term;
  } s2l_entry_t;

  typedef enum logic [2:0] {
    F_IDLE, F_DIV_A, F_DIV_B, F_DIV_C, F_WALK, F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE, B_YEAR, B_MONTH
  } back_state_t;

  localparam logic [16:0] YEAR_ROM [151] = '{
    17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260, 17'h0d950, 17'h16554,
    17'h056a0, 17'h09ad0, 17'h055d2, 17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250,
    17'h1d255, 17'h0b540, 17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977, 17'h04970,
    17'h0a4b0, 17'h0b4b5, 17'h06a50, 17'h06d40, 17'h1ab54, 17'h02b60, 17'h09570,
    17'h052f2, 17'h04970, 17'h06566, 17'h0d4a0, 17'h0ea50, 17'h06e95, 17'h05ad0,
    17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950, 17'h0d4a0, 17'h1d8a6,
    17'h0b550, 17'h056a0, 17'h1a5b4, 17'h025d0, 17'h092d0, 17'h0d2b2, 17'h0a950,
    17'h0b557, 17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5b0, 17'h14573,
    17'h052b0, 17'h0a9a8, 17'h0e950, 17'h06aa0, 17'h0aea6, 17'h0ab50, 17'h04b60,
    17'h0aae4, 17'h0a570, 17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0,
    17'h096d0, 17'h04dd5, 17'h04ad0, 17'h0a4d0, 17'h0d4d4, 17'h0d250, 17'h0d558,
    17'h0b540, 17'h0b6a0, 17'h195a6, 17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0,
    17'h0b27a, 17'h06a50, 17'h06d40, 17'h0af46, 17'h0ab60, 17'h09570, 17'h04af5,
    17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50, 17'h06b58, 17'h055c0, 17'h0ab60,
    17'h096d5, 17'h092e0, 17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50, 17'h07552,
    17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5, 17'h0a950, 17'h0b4a0,
    17'h0baa4, 17'h0ad50, 17'h055d9, 17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0,
    17'h0a930, 17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60, 17'h0a6e6,
    17'h0a4e0, 17'h0d260, 17'h0ea65, 17'h0d530, 17'h05aa0, 17'h076a3, 17'h096d0,
    17'h04bd7, 17'h04ad0, 17'h0a4d0, 17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45,
    17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0, 17'h0a577, 17'h0a4b0, 17'h0aa50,
    17'h1b255, 17'h06d20, 17'h0ada0, 17'h14b63
  };

  localparam logic [18:0] TERM_MINUTES [24] = '{
    19'd0,      19'd21208,  19'd42467,  19'd63836,  19'd85337,  19'd107014,
    19'd128867, 19'd150921, 19'd173149, 19'd195551, 19'd218072, 19'd240693,
    19'd263343, 19'd285989, 19'd308563, 19'd331033, 19'd353350, 19'd375494,
    19'd397447, 19'd419210, 19'd440795, 19'd462224, 19'd483532, 19'd504758
  };

  localparam logic [8:0] DAYS_BEFORE [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
    9'd304, 9'd334
  };

  localparam logic [4:0] MONTH_LEN [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31,
    5'd30, 5'd31
  };

  localparam logic [15:0] BLOCK_BASE [3] = '{16'd0, 16'd18279, 16'd36529};

  function automatic logic [4:0] leap_len(input logic [16:0] w);
    if (w[3:0] == 4'd0) begin
      return 5'd0;
    end
    return w[16] ? 5'd30 : 5'd29;
  endfunction

  function automatic logic [8:0] lunar_year_len(input logic [16:0] w);
    logic [3:0] longs;
    longs = 4'($countones(w[15:4]));
    return SHORT_YEAR + {5'd0, longs} + {4'd0, leap_len(w)};
  endfunction

endpackage

// ===== design/s2l_queue.sv =====
// ----------------------------------------------------------------------------
// s2l_queue
// small register fifo between the front and back parts
// ----------------------------------------------------------------------------
`include "solar_to_lunar_date_converter_defines.svh"

module s2l_queue
  import s2l_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  s2l_entry_t push_data,
  input  logic       pop,
  output s2l_entry_t pop_data,
  output logic       full,
  output logic       empty
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  s2l_entry_t        mem [DEPTH];
  logic [IW-1:0]     wptr;
  logic [IW-1:0]     rptr;
  logic [CW-1:0]     count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == IW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == IW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `S2L_ASSERT_IMP(a_no_push_full, clk, rst, push, !full, "push into full queue")
  `S2L_ASSERT_IMP(a_no_pop_empty, clk, rst, pop, !empty, "pop from empty queue")
  `S2L_ASSERT_NXT(a_count_grows, clk, rst, push && !pop, !empty, "queue lost a transaction")

endmodule

// ===== design/s2l_front.sv =====
// ----------------------------------------------------------------------------
// s2l_front
// accepts a date, checks the range, forms the day offset and finds the
// solar term of the day
// ----------------------------------------------------------------------------
module s2l_front
  import s2l_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [11:0] solar_year,
  input  logic [3:0]  solar_month,
  input  logic [4:0]  solar_day,
  output logic        busy,
  input  logic        q_full,
  output logic        q_push,
  output s2l_entry_t  q_data
);

  front_state_t       state, state_next;
  logic [11:0]        y;
  logic [3:0]         m;
  logic [4:0]         d;
  logic               err;
  logic               tsel;
  logic               neg;
  logic [14:0]        x;
  logic [9:0]         q;
  logic signed [10:0] r;
  logic [3:0]         k;
  logic signed [5:0]  term;

  logic               accept;
  logic               in_ok;
  logic [7:0]         yy;
  logic [11:0]        p;
  logic [9:0]         lraw;
  logic [5:0]         lc;
  logic               gleap;
  logic [1:0]         blk;
  logic [16:0]        days;
  logic [3:0]         m1;
  logic [4:0]         n;
  logic signed [21:0] a;
  logic [21:0]        a_abs;
  logic [25:0]        prod;
  logic [15:0]        rm;
  logic [9:0]         qq;
  logic signed [10:0] r_new;
  logic [4:0]         mlen;
  logic               walking;
  logic               match;

  // derived year quantities, valid while y is in range
  always_comb begin
    yy    = 8'(y - ROM_FIRST_YEAR);
    p     = y - 12'd1;
    lraw  = p[11:2] - LEAP_OFFSET;
    lc    = lraw[5:0];
    gleap = (y[1:0] == 2'b00);
    if (y <= BLK1_LAST_YEAR) begin
      blk = 2'd0;
    end else if (y <= BLK2_LAST_YEAR) begin
      blk = 2'd1;
    end else begin
      blk = 2'd2;
    end
    m1   = m - 4'd1;
    days = 17'(DAYS_PER_YEAR * yy) + {11'd0, lc} + {8'd0, DAYS_BEFORE[m1]}
         + {16'd0, (m > 4'd2) && gleap} + {12'd0, d} - {8'd0, BASE_DAY}
         - {1'b0, BLOCK_BASE[blk]};
    n    = {m1, 1'b0} + {4'd0, tsel};
  end

  // term minute offset and signed division by minutes per day
  always_comb begin
    a = $signed({6'd0, 16'(TERM_YEAR_MIN * yy)})
      - $signed({6'd0, 16'(MIN_PER_DAY * lc)})
      + $signed({3'd0, TERM_MINUTES[n]})
      + $signed({15'd0, TERM_BIAS});
    a_abs = a[21] ? 22'(-a) : 22'(a);
    prod  = x[14:0] * DIV45_RECIP;
    rm    = {1'b0, x} - 16'(q * DIV45);
    qq    = (rm >= {10'd0, DIV45}) ? q + 10'd1 : q;
    r_new = neg ? (11'sd5 - $signed({1'b0, qq})) : (11'sd6 + $signed({1'b0, qq}));
    mlen  = MONTH_LEN[k] + {4'd0, (k == 4'd2) && gleap};
    walking = (r > 11'sd28) && (k < TERM_MONTHS);
    match   = (r == $signed({6'd0, d}));
  end

  always_comb begin
    in_ok = (solar_year >= MIN_YEAR) && (solar_year <= MAX_YEAR)
         && (solar_month >= 4'd1) && (solar_month <= LAST_MONTH);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (start) begin
          state_next = in_ok ? F_DIV_A : F_PUSH;
        end
      end
      F_DIV_A: state_next = F_DIV_B;
      F_DIV_B: state_next = F_DIV_C;
      F_DIV_C: state_next = F_WALK;
      F_WALK: begin
        if (!walking) begin
          state_next = (match || tsel) ? F_PUSH : F_DIV_A;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy   = (state != F_IDLE);
    accept = (state == F_IDLE) && start;
    q_push = (state == F_PUSH) && !q_full;
    q_data.err  = err;
    q_data.blk  = blk;
    q_data.rem  = days[14:0];
    q_data.term = term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y    <= solar_year;
      m    <= solar_month;
      d    <= solar_day;
      err  <= !in_ok;
      tsel <= 1'b0;
      term <= NO_TERM;
    end
    unique case (state)
      F_DIV_A: begin
        neg <= a[21];
        x   <= a_abs[19:5];
      end
      F_DIV_B: q <= prod[25:16];
      F_DIV_C: begin
        r <= r_new;
        k <= 4'd0;
      end
      F_WALK: begin
        if (walking) begin
          r <= r - $signed({6'd0, mlen});
          k <= k + 4'd1;
        end else if (match) begin
          term <= $signed({1'b0, n});
        end else begin
          tsel <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/s2l_back.sv =====
// ----------------------------------------------------------------------------
// s2l_back
// walks lunar years and months from the queued day offset
// ----------------------------------------------------------------------------
module s2l_back
  import s2l_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  s2l_entry_t        q_data,
  output logic              q_pop,
  output logic              done,
  output logic              status,
  output logic [11:0]       lunar_year,
  output logic [3:0]        lunar_month,
  output logic [4:0]        lunar_day,
  output logic              leap_month_flag,
  output logic signed [5:0] solar_term_index
);

  back_state_t       state, state_next;
  logic [7:0]        k;
  logic [14:0]       rem;
  logic [3:0]        mon;
  logic              lf;
  logic signed [5:0] term;

  logic [16:0]       w;
  logic [8:0]        ylen;
  logic              year_step;
  logic [4:0]        bit_idx;
  logic [4:0]        len;
  logic              hit;
  logic              to_leap;
  logic              exhausted;
  logic              finish;

  always_comb begin
    w         = YEAR_ROM[k];
    ylen      = lunar_year_len(w);
    year_step = (k < LAST_YEAR_IDX) && ({6'd0, ylen} <= rem);
    bit_idx   = 5'd16 - {1'b0, mon};
    len       = lf ? leap_len(w) : (w[bit_idx] ? 5'd30 : 5'd29);
    hit       = (rem < {10'd0, len});
    to_leap   = !lf && (mon == w[3:0]);
    exhausted = !hit && !to_leap && (mon == LAST_MONTH);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty && !q_data.err) begin
          state_next = B_YEAR;
        end
      end
      B_YEAR: begin
        if (!year_step) begin
          state_next = B_MONTH;
        end
      end
      B_MONTH: begin
        if (hit || exhausted) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop  = (state == B_IDLE) && !q_empty;
    finish = (state == B_MONTH) && (hit || exhausted);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish || (q_pop && q_data.err);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (q_pop) begin
          k    <= 8'(q_data.blk * YEARS_PER_BLK);
          rem  <= q_data.rem;
          term <= q_data.term;
          mon  <= 4'd1;
          lf   <= 1'b0;
          if (q_data.err) begin
            status           <= 1'b1;
            lunar_year       <= '0;
            lunar_month      <= '0;
            lunar_day        <= '0;
            leap_month_flag  <= 1'b0;
            solar_term_index <= NO_TERM;
          end
        end
      end
      B_YEAR: begin
        if (year_step) begin
          rem <= rem - {6'd0, ylen};
          k   <= k + 8'd1;
        end
      end
      B_MONTH: begin
        if (finish) begin
          status           <= 1'b0;
          lunar_year       <= ROM_FIRST_YEAR + {4'd0, k};
          lunar_month      <= mon;
          lunar_day        <= hit ? (rem[4:0] + 5'd1) : len;
          leap_month_flag  <= lf;
          solar_term_index <= term;
        end else if (to_leap) begin
          rem <= rem - {10'd0, len};
          lf  <= 1'b1;
        end else begin
          rem <= rem - {10'd0, len};
          mon <= mon + 4'd1;
          lf  <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/solar_to_lunar_date_converter.sv =====
// ----------------------------------------------------------------------------
// solar_to_lunar_date_converter
// gregorian date (1901..2050) to chinese lunar date and solar term
// ----------------------------------------------------------------------------
// usage: drive solar_year, solar_month and solar_day and raise start while
// busy is low; that edge takes the transaction. the front part then forms
// the day offset and checks the solar terms (a rejected date skips both),
// waits while the queue is full and hands the transaction to a small queue,
// after which busy drops and the next date can be taken.
// the back part walks lunar years (up to 50 steps from the base of the
// 50-year block) and then lunar months (up to 13 steps counting the leap
// month), one step a cycle, so done rises once both walks are through; the
// year walk can take the most steps. each result is shown for exactly one
// cycle with done high and is not held: the receiver must take it then. a
// year outside 1901..2050 or a month outside 1..12 gives status 1 with zero
// lunar fields and solar_term_index -1 once it has passed the queue and the
// back part is free.
// results leave in the order the dates were taken.
// ----------------------------------------------------------------------------
`include "solar_to_lunar_date_converter_defines.svh"

module solar_to_lunar_date_converter
  import s2l_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [11:0]       solar_year,
  input  logic [3:0]        solar_month,
  input  logic [4:0]        solar_day,
  output logic              done,
  output logic              status,
  output logic [11:0]       lunar_year,
  output logic [3:0]        lunar_month,
  output logic [4:0]        lunar_day,
  output logic              leap_month_flag,
  output logic signed [5:0] solar_term_index
);

  // queue handshake between the two halves
  s2l_entry_t push_data;
  s2l_entry_t pop_data;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;

  // front: range check, day offset, solar term search
  s2l_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .solar_year  (solar_year),
    .solar_month (solar_month),
    .solar_day   (solar_day),
    .busy        (busy),
    .q_full      (full),
    .q_push      (push),
    .q_data      (push_data)
  );

  // decoupling queue
  s2l_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  // back: lunar year and month walk, result strobe
  s2l_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (empty),
    .q_data           (pop_data),
    .q_pop            (pop),
    .done             (done),
    .status           (status),
    .lunar_year       (lunar_year),
    .lunar_month      (lunar_month),
    .lunar_day        (lunar_day),
    .leap_month_flag  (leap_month_flag),
    .solar_term_index (solar_term_index)
  );

  // a taken transaction always sets the front busy
  `S2L_ASSERT_NXT(a_busy_after_start, clk, rst, start && !busy, busy, "front missed a start")
  // rejected dates carry zero lunar fields and no term
  `S2L_ASSERT_IMP(a_err_fields, clk, rst, done && status,
    lunar_year == 12'd0 && solar_term_index == -6'sd1, "bad error result")
  // a good result never has day zero or month zero
  `S2L_ASSERT_IMP(a_good_fields, clk, rst, done && !status,
    lunar_day != 5'd0 && lunar_month != 4'd0, "bad lunar result")

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench of the solar to lunar date converter
// ----------------------------------------------------------------------------
// a driver feeds dates from a queue with random start gaps, and a local model
// of the converter computes the expected lunar date for every accepted
// transaction. a monitor compares each done strobe with the oldest expected
// lunar date. directed corner dates come first, then mostly valid random dates
// mixed with out-of-range years, months and days.
// ----------------------------------------------------------------------------
module testbench
  import s2l_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 400;

  typedef struct {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } solar_date_t;

  typedef struct {
    logic              status;
    logic [11:0]       year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic              leap;
    logic signed [5:0] term;
  } lunar_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [11:0]       solar_year = '0;
  logic [3:0]        solar_month = '0;
  logic [4:0]        solar_day = '0;
  logic              done;
  logic              status;
  logic [11:0]       lunar_year;
  logic [3:0]        lunar_month;
  logic [4:0]        lunar_day;
  logic              leap_month_flag;
  logic signed [5:0] solar_term_index;

  solar_date_t   pending_dates[$];
  lunar_result_t expected_dates[$];
  int            error_count = 0;
  int            cycle_count = 0;
  int            sent_count = 0;

  solar_to_lunar_date_converter u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .solar_year(solar_year), .solar_month(solar_month), .solar_day(solar_day),
    .done(done), .status(status), .lunar_year(lunar_year),
    .lunar_month(lunar_month), .lunar_day(lunar_day),
    .leap_month_flag(leap_month_flag), .solar_term_index(solar_term_index)
  );

  always #10 clk = ~clk;

  function automatic bit greg_leap(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  // gregorian leap days in 1901..y-1
  function automatic int unsigned leaps_after_1900(int unsigned y);
    int unsigned p;
    p = y - 1;
    return p / 4 - p / 100 + p / 400 - 460;
  endfunction

  function automatic logic [16:0] year_word(int unsigned ly);
    if (ly - 1900 < 151) begin
      return YEAR_ROM[ly - 1900];
    end
    return '0;
  endfunction

  function automatic int leap_days(logic [16:0] w);
    if (w[3:0] == 4'd0) begin
      return 0;
    end
    return w[16] ? 30 : 29;
  endfunction

  function automatic int lunar_days_in_year(logic [16:0] w);
    int sum;
    sum = 348;
    for (int b = 15; b >= 4; b--) begin
      if (w[b]) sum++;
    end
    return sum + leap_days(w);
  endfunction

  // gregorian day of month of solar term n in year y
  function automatic longint term_day_of(int unsigned y, int unsigned n);
    longint yy, days, a, r;
    int     len;
    yy = y - 1900;
    days = yy * 365 + longint'(leaps_after_1900(y));
    a = 64'sd525948 * yy - days * 1440 + longint'(TERM_MINUTES[n]) + 125;
    r = (a < 0) ? -1 : 0;
    r = r + 6 + a / 1440;
    for (int k = 0; k < 13 && r > 28; k++) begin
      len = MONTH_LEN[k];
      if (k == 2 && greg_leap(y)) len++;
      r -= len;
    end
    return r;
  endfunction

  function automatic lunar_result_t convert_date(solar_date_t sd);
    lunar_result_t res;
    int unsigned y, m, d, blk, ly, leapm, lmon, llen, len, n;
    logic [16:0] w;
    int          rem;
    bit          found, lflag;
    y = sd.year; m = sd.month; d = sd.day;
    res = '{1'b1, '0, '0, '0, 1'b0, NO_TERM};
    if (y < 1901 || y > 2050 || m < 1 || m > 12) begin
      return res;
    end
    rem = 365 * (y - 1900) + leaps_after_1900(y) + DAYS_BEFORE[m - 1]
          + ((m > 2 && greg_leap(y)) ? 1 : 0) + d - 31;
    blk = (y - 1901) / 50;
    if (blk > 2) blk = 2;
    rem -= BLOCK_BASE[blk];
    ly = 1900 + blk * 50;
    while (ly < 2050 && rem >= lunar_days_in_year(year_word(ly))) begin
      rem -= lunar_days_in_year(year_word(ly));
      ly++;
    end
    w = year_word(ly);
    leapm = w[3:0];
    lmon = 12; llen = 0; lflag = 0; found = 0;
    for (int unsigned mon = 1; mon <= 12 && !found; mon++) begin
      len = w[16 - mon] ? 30 : 29;
      lmon = mon; lflag = 0; llen = len;
      if (rem < int'(len)) begin
        found = 1;
      end else begin
        rem -= len;
        if (mon == leapm) begin
          len = leap_days(w);
          lflag = 1; llen = len;
          if (rem < int'(len)) found = 1;
          else rem -= len;
        end
      end
    end
    if (!found) rem = llen - 1;
    n = (m - 1) * 2;
    res.term = NO_TERM;
    if (longint'(d) == term_day_of(y, n)) res.term = 6'(n);
    else if (longint'(d) == term_day_of(y, n + 1)) res.term = 6'(n + 1);
    res.status = 1'b0;
    res.year = 12'(ly);
    res.month = 4'(lmon);
    res.day = 5'(rem + 1);
    res.leap = lflag;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  function automatic bit take_gap();
    // no start gaps in the middle of the random part
    if (sent_count >= 150 && sent_count < 260) return 0;
    return $urandom_range(99) < 6;
  endfunction

  // driver: start stays high until the transaction is taken
  always @(posedge clk) begin
    solar_date_t nd;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        expected_dates.push_back(convert_date('{solar_year, solar_month, solar_day}));
        sent_count++;
      end
      if (pending_dates.size() > 0 && !take_gap()) begin
        nd = pending_dates.pop_front();
        solar_year <= nd.year;
        solar_month <= nd.month;
        solar_day <= nd.day;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every done pulse must match the oldest expected lunar date
  always @(posedge clk) begin
    lunar_result_t e;
    if (!rst && done) begin
      if (expected_dates.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        e = expected_dates.pop_front();
        if (status !== e.status) report_mismatch("status", status, e.status);
        if (lunar_year !== e.year) report_mismatch("lunar_year", lunar_year, e.year);
        if (lunar_month !== e.month) report_mismatch("lunar_month", lunar_month, e.month);
        if (lunar_day !== e.day) report_mismatch("lunar_day", lunar_day, e.day);
        if (leap_month_flag !== e.leap)
          report_mismatch("leap_month_flag", leap_month_flag, e.leap);
        if (solar_term_index !== e.term)
          report_mismatch("solar_term_index", solar_term_index, e.term);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("solar_to_lunar_date_converter test failed");
      $finish;
    end
  end

  task automatic add_date(int y, int m, int d);
    pending_dates.push_back('{12'(y), 4'(m), 5'(d)});
  endtask

  initial begin
    int sel;
    // range edges, block boundaries, bad years and months
    add_date(1901, 1, 1);
    add_date(2050, 12, 31);
    add_date(1900, 12, 31);
    add_date(2051, 1, 1);
    add_date(0, 0, 0);
    add_date(4095, 15, 31);
    add_date(2000, 0, 15);
    add_date(2000, 13, 15);
    add_date(1950, 12, 31);
    add_date(1951, 1, 1);
    add_date(2000, 12, 31);
    add_date(2001, 1, 1);
    // day zero and days past the end of the month run on linearly
    add_date(1999, 3, 0);
    add_date(2024, 2, 30);
    add_date(2023, 2, 31);
    add_date(1985, 4, 31);
    // leap month dates
    add_date(2020, 5, 23);
    add_date(2020, 6, 20);
    add_date(2017, 7, 23);
    // solar term days
    add_date(2024, 2, 4);
    add_date(2024, 12, 21);
    add_date(1912, 6, 21);
    add_date(2050, 1, 5);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(99);
      if (sel < 85) begin
        add_date($urandom_range(2050, 1901), $urandom_range(12, 1), $urandom_range(31, 1));
      end else if (sel < 93) begin
        add_date($urandom_range(2050, 1901), $urandom_range(15), $urandom_range(31));
      end else begin
        add_date($urandom_range(4095), $urandom_range(15), $urandom_range(31));
      end
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (pending_dates.size() > 0 || start || expected_dates.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_dates.size() != 0) begin
      report_mismatch("missing transactions", 0, expected_dates.size());
    end
    if (error_count == 0) begin
      $display("solar_to_lunar_date_converter test passed");
    end else begin
      $display("solar_to_lunar_date_converter test failed");
    end
    $finish;
  end

endmodule
